// ===== hw/rtl/conv3x3_border_pass_clamp_unit_macros.svh =====
// Assertion macros for the 3x3 border-pass convolution block.
`ifndef CONV3X3_BORDER_PASS_CLAMP_UNIT_MACROS_SVH
`define CONV3X3_BORDER_PASS_CLAMP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define C3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define C3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define C3_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define C3_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/c3bpc_pkg.sv =====
// Types and constants of the 3x3 border-pass convolution block.
`default_nettype none
package c3bpc_pkg;
  localparam int PIX_W       = 8;
  localparam int SIZE_BITS   = 11;
  localparam int PIX_MAX     = 255;
  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = 3;
  localparam int REG_IDX_W   = 3;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

  typedef struct packed {
    logic res;
    logic border;
    logic last;
  } stage_flags_t;
endpackage
`default_nettype wire

// ===== hw/rtl/conv3x3_border_pass_clamp_unit.sv =====
// 3x3 convolution top: line memory, window, multiply pipeline, output queue.
// A result passes the input, window, product and row-sum registers and the output queue before it is visible.
// Throughput: one beat per cycle while input is not held off; the line memory does one read and one write per cycle.
// Input is held off only when the 8-entry output queue plus results in flight is full.
// Reset: sizes 1024x1024 (clamped), identity kernel, counters and window cleared.
// The line memory is not cleared; entries not yet written in a frame feed only border results.
`default_nettype none
`include "conv3x3_border_pass_clamp_unit_macros.svh"
module conv3x3_border_pass_clamp_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int COEF_BITS  = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [c3bpc_pkg::REG_IDX_W-1:0]   cfg_index,
  input  wire logic [3*COEF_BITS-1:0]            cfg_data,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // pixel_in
  input  wire logic                              s_axis_tuser,  // cmd
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [7:0]                             m_axis_tdata,  // pixel_out
  output logic                                   m_axis_tlast   // frame_last
);
  import c3bpc_pkg::*;

  localparam int KREG_W  = 3 * COEF_BITS;
  localparam int WMAX    = (MAX_WIDTH < 2047) ? MAX_WIDTH : 2047;
  localparam int HMAX    = (MAX_HEIGHT < 2047) ? MAX_HEIGHT : 2047;
  localparam int CNT_W   = $clog2(WMAX * HMAX + WMAX + 2);
  localparam int AW      = $clog2(MAX_WIDTH);
  localparam int PROD_W  = PIX_W + 1 + COEF_BITS;
  localparam int ROW_W   = PROD_W + 2;
  localparam int SUM_W   = PROD_W + 4;

  function automatic logic [SIZE_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v,
                                                      input int unsigned maxv);
    logic [SIZE_BITS-1:0] r;
    r = v;
    if (v == '0) r = SIZE_BITS'(1);
    else if (32'(v) > maxv) r = SIZE_BITS'(maxv);
    return r;
  endfunction

  // configuration
  logic [SIZE_BITS-1:0] w_size, h_size;
  logic [CNT_W-1:0]     total;
  logic [KREG_W-1:0]    kreg [3];
  logic [SIZE_BITS-1:0] cfg_sz, new_w, new_h;
  logic [2*SIZE_BITS-1:0] new_total;

  always_comb begin
    cfg_sz    = cfg_data[SIZE_BITS-1:0];
    new_w     = (cfg_index == REG_IMAGE_WIDTH) ? clamp_size(cfg_sz, WMAX) : w_size;
    new_h     = (cfg_index == REG_IMAGE_HEIGHT) ? clamp_size(cfg_sz, HMAX) : h_size;
    new_total = (2*SIZE_BITS)'(new_w) * (2*SIZE_BITS)'(new_h);
  end

  // frame counters
  logic [CNT_W-1:0]     in_count, out_count;
  logic [AW-1:0]        in_col;
  logic [SIZE_BITS-1:0] out_col, out_row;

  logic         beat_in, is_pixel, acc_push, res, last_res, border;
  logic [CNT_W-1:0] in_next;

  // pipeline
  logic                  p1_vld, p1_fwd;
  logic [AW-1:0]         p1_addr;
  logic [PIX_W-1:0]      p1_px;
  logic [2*PIX_W-1:0]    p1_fdata, ram_q, p1_rd, p1_wdata;
  stage_flags_t          p1_fl, p2_fl, p3_fl, p4_fl;
  logic [PIX_W-1:0]      win [9];
  logic signed [PROD_W-1:0] prod [9];
  logic signed [ROW_W-1:0]  rsum [3];
  logic [PIX_W-1:0]      c3, c4;
  logic signed [SUM_W-1:0]  sum;
  logic [PIX_W-1:0]      result;

  logic [2*PIX_W-1:0]    line_mem [MAX_WIDTH];

  // output queue
  logic [PIX_W:0]        fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]    wr_ptr, rd_ptr;
  logic [FIFO_AW:0]      fifo_cnt;
  logic [2:0]            pend;
  logic                  fifo_wr, fifo_rd;

  always_comb begin
    pend = 3'(p1_fl.res) + 3'(p2_fl.res) + 3'(p3_fl.res) + 3'(p4_fl.res);
    s_axis_tready = ((FIFO_AW+2)'(fifo_cnt) + (FIFO_AW+2)'(pend)) < (FIFO_AW+2)'(FIFO_DEPTH);
    beat_in  = s_axis_tvalid && s_axis_tready;
    is_pixel = (s_axis_tuser == CMD_PIXEL);
    acc_push = beat_in && (is_pixel ? (in_count < total)
                                    : (in_count >= total && out_count < total));
    in_next  = in_count + CNT_W'(1);
    res      = acc_push && (in_next >= CNT_W'(w_size) + CNT_W'(2));
    last_res = res && (out_count + CNT_W'(1) >= total);
    border   = (out_row == '0) || (out_row == h_size - SIZE_BITS'(1)) ||
               (out_col == '0) || (out_col == w_size - SIZE_BITS'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_size    <= clamp_size(SIZE_BITS'(1024), WMAX);
      h_size    <= clamp_size(SIZE_BITS'(1024), HMAX);
      total     <= CNT_W'(WMAX * HMAX);
      kreg[0]   <= '0;
      kreg[1]   <= KREG_W'(256);
      kreg[2]   <= '0;
      in_count  <= '0;
      out_count <= '0;
      in_col    <= '0;
      out_col   <= '0;
      out_row   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT: begin
          w_size    <= new_w;
          h_size    <= new_h;
          total     <= CNT_W'(new_total);
          in_count  <= '0;
          out_count <= '0;
          in_col    <= '0;
          out_col   <= '0;
          out_row   <= '0;
        end
        REG_KERNEL_TOP: kreg[0] <= cfg_data;
        REG_KERNEL_MID: kreg[1] <= cfg_data;
        REG_KERNEL_BOT: kreg[2] <= cfg_data;
        default: ;
      endcase
    end else if (acc_push) begin
      if (last_res) begin
        in_count  <= '0;
        out_count <= '0;
        in_col    <= '0;
        out_col   <= '0;
        out_row   <= '0;
      end else begin
        in_count <= in_next;
        in_col   <= (32'(in_col) == 32'(w_size) - 1) ? '0 : in_col + AW'(1);
        if (res) begin
          out_count <= out_count + CNT_W'(1);
          if (out_col == w_size - SIZE_BITS'(1)) begin
            out_col <= '0;
            out_row <= out_row + SIZE_BITS'(1);
          end else begin
            out_col <= out_col + SIZE_BITS'(1);
          end
        end
      end
    end
  end

  // line memory: entry holds {two rows back, one row back}
  always_comb begin
    p1_rd    = p1_fwd ? p1_fdata : ram_q;
    p1_wdata = {p1_rd[PIX_W-1:0], p1_px};
  end

  always_ff @(posedge clk) begin
    if (acc_push) ram_q <= line_mem[in_col];
    if (p1_vld) line_mem[p1_addr] <= p1_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p1_fl  <= '0;
      p2_fl  <= '0;
      p3_fl  <= '0;
      p4_fl  <= '0;
      for (int i = 0; i < 9; i++) win[i] <= '0;
    end else begin
      p1_vld       <= acc_push && !cfg_we;
      p1_fl.res    <= res && !cfg_we;
      p1_fl.border <= border;
      p1_fl.last   <= last_res;
      if (p1_vld) begin
        for (int r = 0; r < 3; r++) begin
          win[r*3]   <= win[r*3+1];
          win[r*3+1] <= win[r*3+2];
        end
        win[2] <= p1_rd[2*PIX_W-1:PIX_W];
        win[5] <= p1_rd[PIX_W-1:0];
        win[8] <= p1_px;
      end
      p2_fl <= p1_fl;
      p3_fl <= p2_fl;
      p4_fl <= p3_fl;
    end
  end

  always_ff @(posedge clk) begin
    p1_addr  <= in_col;
    p1_px    <= is_pixel ? s_axis_tdata : '0;
    p1_fwd   <= p1_vld && (p1_addr == in_col);
    p1_fdata <= p1_wdata;
    for (int i = 0; i < 9; i++) begin
      prod[i] <= $signed({1'b0, win[i]}) *
                 $signed(kreg[i/3][(i%3)*COEF_BITS +: COEF_BITS]);
    end
    c3 <= win[4];
    for (int r = 0; r < 3; r++) begin
      rsum[r] <= ROW_W'(prod[r*3]) + ROW_W'(prod[r*3+1]) + ROW_W'(prod[r*3+2]);
    end
    c4 <= c3;
  end

  always_comb begin
    sum = SUM_W'(rsum[0]) + SUM_W'(rsum[1]) + SUM_W'(rsum[2]);
    if (p4_fl.border) result = c4;
    else if (sum < 0) result = '0;
    else if (sum > SUM_W'(PIX_MAX)) result = PIX_W'(PIX_MAX);
    else result = sum[PIX_W-1:0];
    fifo_wr = p4_fl.res;
    fifo_rd = m_axis_tvalid && m_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (fifo_wr) fifo_mem[wr_ptr] <= {p4_fl.last, result};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (fifo_wr) wr_ptr <= wr_ptr + FIFO_AW'(1);
      if (fifo_rd) rd_ptr <= rd_ptr + FIFO_AW'(1);
      fifo_cnt <= fifo_cnt + (FIFO_AW+1)'(fifo_wr) - (FIFO_AW+1)'(fifo_rd);
    end
  end

  assign m_axis_tvalid = (fifo_cnt != '0);
  assign m_axis_tdata  = fifo_mem[rd_ptr][PIX_W-1:0];
  assign m_axis_tlast  = fifo_mem[rd_ptr][PIX_W];

  `C3_ASSERT_IMP(a_credit, clk, rst, 1'b1, ((FIFO_AW+2)'(fifo_cnt) + (FIFO_AW+2)'(pend)) <= (FIFO_AW+2)'(FIFO_DEPTH), "output queue overrun possible")
  `C3_ASSERT_IMP(a_fwd_col0, clk, rst, p1_vld && p1_fwd, p1_addr == '0, "forward on nonzero column")
  `C3_ASSERT_IMP(a_last_clr, clk, rst, p1_vld && p1_fl.last, (in_count == '0) && (out_count == '0), "counters not cleared at frame end")
  `C3_ASSERT_NXT(a_no_push, clk, rst, beat_in && !acc_push, !p1_vld && !p1_fl.res, "ignored beat entered pipeline")
endmodule
`default_nettype wire

// ===== tb/tb_conv3x3_border_pass_clamp_unit.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the 3x3 border-pass convolution block.
module tb_conv3x3_border_pass_clamp_unit;
  import c3bpc_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_BEATS  = 450;
  localparam int CALM_BEATS    = 380;

  localparam logic [7:0] DIR_PIX [0:8] = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd1,
                                           8'd254, 8'd255, 8'd0, 8'd85};

  typedef struct packed {
    logic       cmd;
    logic [7:0] pix;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       last;
  } out_beat_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index     = REG_IMAGE_WIDTH;
  logic [23:0]          cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // pixel_in
  logic                 s_axis_tuser  = CMD_PIXEL;  // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;  // pixel_out
  logic                 m_axis_tlast;  // frame_last

  conv3x3_border_pass_clamp_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [10:0] width_reg;
  logic [10:0] height_reg;
  logic [23:0] kern_reg [0:2];
  logic [7:0]  line_mem [0:2*MAX_W-1];
  logic [7:0]  win [0:8];
  int unsigned pix_cnt;
  int unsigned res_cnt;

  in_beat_t  in_beats_q [$];
  out_beat_t filtered_q [$];
  in_beat_t  next_beat;
  in_beat_t  taken;
  out_beat_t want;
  out_beat_t got_want;

  int unsigned beats_queued  = 0;
  int unsigned beats_taken   = 0;
  int unsigned frame_items   = 0;
  int unsigned results_seen  = 0;
  int unsigned frames_seen   = 0;
  int unsigned settings_used = 0;
  int unsigned errors        = 0;
  int unsigned send_gap      = 0;
  int unsigned rdy_gap       = 0;
  bit          calm          = 1'b0;

  function automatic int unsigned eff_size(input logic [10:0] v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic bit filter_predict(input in_beat_t b, output out_beat_t r);
    int unsigned w, h, total, col, row, ocol;
    int i, j, sum;
    logic [7:0] px;
    logic signed [7:0] cf;
    r = '0;
    w = eff_size(width_reg, MAX_W);
    h = eff_size(height_reg, MAX_H);
    total = w * h;
    if (b.cmd == CMD_PIXEL) begin
      if (pix_cnt >= total) return 0;
      px = b.pix;
    end else begin
      if (pix_cnt < total || res_cnt >= total) return 0;
      px = 8'd0;
    end
    col = pix_cnt % w;
    for (i = 0; i < 3; i++) begin
      win[3*i]   = win[3*i+1];
      win[3*i+1] = win[3*i+2];
    end
    win[2] = line_mem[MAX_W + col];
    win[5] = line_mem[col];
    win[8] = px;
    line_mem[MAX_W + col] = line_mem[col];
    line_mem[col] = px;
    pix_cnt++;
    if (pix_cnt < w + 2) return 0;
    row  = res_cnt / w;
    ocol = res_cnt % w;
    if (row == 0 || row == h - 1 || ocol == 0 || ocol == w - 1) begin
      r.pix = win[4];
    end else begin
      sum = 0;
      for (i = 0; i < 3; i++) begin
        for (j = 0; j < 3; j++) begin
          cf = kern_reg[i][8*j +: 8];
          sum += int'(win[3*i+j]) * int'(cf);
        end
      end
      if (sum < 0) sum = 0;
      if (sum > PIX_MAX) sum = PIX_MAX;
      r.pix = sum[7:0];
    end
    res_cnt++;
    if (res_cnt >= total) begin
      r.last  = 1'b1;
      pix_cnt = 0;
      res_cnt = 0;
    end
    return 1;
  endfunction

  function automatic logic [23:0] pick_kernel_row();
    logic [23:0] v;
    int k;
    case ($urandom_range(0, 9)) inside
      0:      v = 24'h808080;
      1:      v = 24'h7F7F7F;
      [2:4]:  v = 24'($urandom);
      default: begin
        for (k = 0; k < 3; k++) v[8*k +: 8] = 8'($urandom_range(0, 6)) - 8'd3;
      end
    endcase
    return v;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("mismatch: %s", what);
  endtask

  task automatic wait_idle();
    do @(posedge clk); while (beats_taken != beats_queued || filtered_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [23:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = data[10:0];
        pix_cnt = 0;
        res_cnt = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = data[10:0];
        pix_cnt = 0;
        res_cnt = 0;
      end
      REG_KERNEL_TOP: kern_reg[0] = data;
      REG_KERNEL_MID: kern_reg[1] = data;
      REG_KERNEL_BOT: kern_reg[2] = data;
      default: ;
    endcase
  endtask

  task automatic configure(input bit sizes, input bit kernels, input logic [23:0] wdat,
                           input logic [23:0] hdat, input logic [23:0] top,
                           input logic [23:0] mid, input logic [23:0] bot);
    wait_idle();
    if (sizes) begin
      write_reg(REG_IMAGE_WIDTH, wdat);
      write_reg(REG_IMAGE_HEIGHT, hdat);
    end
    if (kernels) begin
      write_reg(REG_KERNEL_TOP, top);
      write_reg(REG_KERNEL_MID, mid);
      write_reg(REG_KERNEL_BOT, bot);
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_beat(input logic cmd, input logic [7:0] pix);
    in_beats_q.push_back({cmd, pix});
    beats_queued++;
  endtask

  // full frame plus drains, or a broken one; stray drains and pixels mixed in
  task automatic queue_frame(input int unsigned w, input int unsigned h, input bit broken);
    int unsigned total, n_pix, n_drain, k;
    total   = w * h;
    n_pix   = total;
    n_drain = w + 1;
    if (broken) begin
      n_pix   = $urandom_range(0, total);
      n_drain = $urandom_range(0, w + 2);
    end
    for (k = 0; k < n_pix; k++) begin
      if ($urandom_range(0, 49) == 0) queue_beat(CMD_DRAIN, 8'($urandom));
      queue_beat(CMD_PIXEL, 8'($urandom));
    end
    for (k = 0; k < n_drain; k++) begin
      if ($urandom_range(0, 49) == 0) queue_beat(CMD_PIXEL, 8'($urandom));
      queue_beat(CMD_DRAIN, 8'($urandom));
    end
    if ($urandom_range(0, 7) == 0) queue_beat(CMD_DRAIN, 8'($urandom));
    frame_items += n_pix + n_drain;
  endtask

  // sender
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (in_beats_q.size() != 0) begin
        next_beat = in_beats_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_beat.pix;
        s_axis_tuser  <= next_beat.cmd;
        if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 4);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rdy_gap <= 0;
    end else if (rdy_gap != 0) begin
      m_axis_tready <= 1'b0;
      rdy_gap <= rdy_gap - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) rdy_gap <= $urandom_range(1, 4);
    end
  end

  // input beats into the predictor
  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      taken = {s_axis_tuser, s_axis_tdata};
      if (filter_predict(taken, want)) filtered_q.push_back(want);
      beats_taken++;
    end
  end

  // output beats against the predicted pixels
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (m_axis_tlast) frames_seen++;
      if (filtered_q.size() == 0) begin
        flag_error($sformatf("unexpected beat pixel=%0d last=%0b", m_axis_tdata, m_axis_tlast));
      end else begin
        got_want = filtered_q.pop_front();
        if (m_axis_tdata !== got_want.pix || m_axis_tlast !== got_want.last)
          flag_error($sformatf("beat %0d: pixel exp %0d got %0d, last exp %0b got %0b",
                               results_seen, got_want.pix, m_axis_tdata,
                               got_want.last, m_axis_tlast));
      end
    end
  end

  initial begin
    int unsigned i, n, guard;
    logic [23:0] wdat, hdat;
    width_reg  = 11'd1024;
    height_reg = 11'd1024;
    kern_reg[0] = 24'd0;
    kern_reg[1] = 24'd256;
    kern_reg[2] = 24'd0;
    for (i = 0; i < 2 * MAX_W; i++) line_mem[i] = 8'd0;
    for (i = 0; i < 9; i++) win[i] = 8'd0;
    pix_cnt = 0;
    res_cnt = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // reset kernel (identity) on a 3x3 frame, early drain first
    configure(1'b1, 1'b0, 24'd3, 24'd3, 24'd0, 24'd0, 24'd0);
    queue_beat(CMD_DRAIN, 8'hA5);
    for (i = 0; i < 9; i++) queue_beat(CMD_PIXEL, DIR_PIX[i]);
    for (i = 0; i < 4; i++) queue_beat(CMD_DRAIN, 8'h00);

    // extreme coefficients, pixel after frame full, surplus drain
    configure(1'b0, 1'b1, 24'd0, 24'd0, 24'h7F7F7F, 24'h7F807F, 24'h7F7F7F);
    for (i = 0; i < 9; i++) queue_beat(CMD_PIXEL, 8'd255);
    queue_beat(CMD_PIXEL, 8'h3C);
    for (i = 0; i < 4; i++) queue_beat(CMD_DRAIN, 8'hFF);
    queue_beat(CMD_DRAIN, 8'h5A);

    // widest row (clamped), single row, partly drained
    configure(1'b1, 1'b1, {13'($urandom), 11'h7FF}, {13'($urandom), 11'd0},
              pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    for (i = 0; i < MAX_W; i++) queue_beat(CMD_PIXEL, 8'($urandom));
    for (i = 0; i < 8; i++) queue_beat(CMD_DRAIN, 8'h00);

    // tallest frame (clamped), partial, then restarted by the next size write
    configure(1'b1, 1'b1, 24'd3, {13'($urandom), 11'h7FF},
              pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
    queue_frame(3, 20, 1'b0);

    frame_items = 0;
    while (frame_items < RANDOM_BEATS) begin
      case ($urandom_range(0, 9)) inside
        0:       wdat = 24'd0;
        1:       wdat = 24'd1;
        [2:7]:   wdat = 24'($urandom_range(2, 8));
        default: wdat = 24'($urandom_range(9, 24));
      endcase
      case ($urandom_range(0, 9)) inside
        0:       hdat = 24'd0;
        1:       hdat = 24'd1;
        [2:7]:   hdat = 24'($urandom_range(2, 6));
        default: hdat = 24'($urandom_range(7, 12));
      endcase
      wdat[23:11] = 13'($urandom);
      hdat[23:11] = 13'($urandom);
      configure(frame_items == 0 || $urandom_range(0, 3) != 0, 1'b1, wdat, hdat,
                pick_kernel_row(), pick_kernel_row(), pick_kernel_row());
      calm = (frame_items >= CALM_BEATS);
      n = $urandom_range(1, 3);
      for (i = 0; i < n; i++)
        queue_frame(eff_size(width_reg, MAX_W), eff_size(height_reg, MAX_H),
                    $urandom_range(0, 5) == 0);
    end

    for (guard = 0; guard < 20000; guard++) begin
      if (beats_taken == beats_queued && filtered_q.size() == 0) break;
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (beats_taken != beats_queued || filtered_q.size() != 0) begin
      errors++;
      $display("stalled: %0d beats unsent, %0d filtered pixels never came out",
               beats_queued - beats_taken, filtered_q.size());
    end

    $display("Covered %0d settings and %0d input beats, incl. clamped sizes and stray drains.",
             settings_used, beats_taken);
    $display("Checked %0d output pixels, %0d of them closing a frame.",
             results_seen, frames_seen);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/c3bpc_pkg.sv
hw/rtl/conv3x3_border_pass_clamp_unit.sv
tb/tb_conv3x3_border_pass_clamp_unit.sv
